// File: hw/rtl/qrv_pkg.sv
// ----------------------------------------------------------------------------
// qrv_pkg: shared types and constants for the quaternion vector rotator
// Payload structs for both channels, matrix row and vector bundles, and
// the fixed-point constants used by the matrix and lane stages.
// ----------------------------------------------------------------------------
package qrv_pkg;

	// Field widths
	localparam int QUAT_W  = 16;   // Q2.14 quaternion component
	localparam int VEC_W   = 32;   // Q16.16 vector coordinate
	localparam int ENTRY_W = 32;   // Q25 matrix entry
	localparam int WIDE_W  = 35;   // exact Q28 matrix entry before rounding
	localparam int PROD_W  = 64;   // Q41 entry x coordinate product and row sum
	localparam int ROW_W   = 39;   // Q23.16 row sum after rounding, before saturation

	// Rounding shifts
	localparam int ENTRY_SHIFT = 3;
	localparam int ROW_SHIFT   = 25;

	// 1.0 in Q28 and the half-LSB rounding terms
	localparam logic signed [WIDE_W-1:0] ONE_Q28   = WIDE_W'(64'sd1 <<< 28);
	localparam logic signed [WIDE_W-1:0] ENTRY_RND = WIDE_W'(64'sd1 <<< (ENTRY_SHIFT - 1));
	localparam logic signed [PROD_W-1:0] ROW_RND   = PROD_W'(64'sd1 <<< (ROW_SHIFT - 1));

	// Input transfer: quaternion and vector
	typedef struct packed {
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
		logic signed [QUAT_W-1:0] quat_w;
		logic signed [VEC_W-1:0]  vec_x;
		logic signed [VEC_W-1:0]  vec_y;
		logic signed [VEC_W-1:0]  vec_z;
	} item_t;

	// Output transfer: rotated vector
	typedef struct packed {
		logic signed [VEC_W-1:0] rot_x;
		logic signed [VEC_W-1:0] rot_y;
		logic signed [VEC_W-1:0] rot_z;
	} rot_t;

	// One row of the rotation matrix in Q25
	typedef struct packed {
		logic signed [ENTRY_W-1:0] c0;
		logic signed [ENTRY_W-1:0] c1;
		logic signed [ENTRY_W-1:0] c2;
	} mat_row_t;

	// Vector carried alongside the matrix build
	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] z;
	} vec_t;

endpackage

// File: hw/rtl/qrv_matrix.sv
// ----------------------------------------------------------------------------
// qrv_matrix: quaternion to rotation matrix
// Stage 1 forms the nine quaternion products, stage 2 combines them into
// the nine matrix entries in Q28 and rounds each to Q25.
// ----------------------------------------------------------------------------
module qrv_matrix (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [qrv_pkg::QUAT_W-1:0]    quat_x,
	input  logic signed [qrv_pkg::QUAT_W-1:0]    quat_y,
	input  logic signed [qrv_pkg::QUAT_W-1:0]    quat_z,
	input  logic signed [qrv_pkg::QUAT_W-1:0]    quat_w,
	output qrv_pkg::mat_row_t                    row0_s2,
	output qrv_pkg::mat_row_t                    row1_s2,
	output qrv_pkg::mat_row_t                    row2_s2
);

	localparam int QP_W = 2 * qrv_pkg::QUAT_W;
	localparam int WW   = qrv_pkg::WIDE_W;

	logic signed [QP_W-1:0] xx_s1, yy_s1, zz_s1;
	logic signed [QP_W-1:0] xy_s1, xz_s1, yz_s1;
	logic signed [QP_W-1:0] wx_s1, wy_s1, wz_s1;

	logic signed [WW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	// Add half an LSB and drop three bits (round half up)
	function automatic logic signed [qrv_pkg::ENTRY_W-1:0] round_entry(
		input logic signed [WW-1:0] v
	);
		logic signed [WW-1:0] t;
		t = v + qrv_pkg::ENTRY_RND;
		return t[qrv_pkg::ENTRY_SHIFT +: qrv_pkg::ENTRY_W];
	endfunction

	// Stage 1: quaternion products, exact in Q4.28
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= QP_W'(quat_x) * QP_W'(quat_x);
			yy_s1 <= QP_W'(quat_y) * QP_W'(quat_y);
			zz_s1 <= QP_W'(quat_z) * QP_W'(quat_z);
			xy_s1 <= QP_W'(quat_x) * QP_W'(quat_y);
			xz_s1 <= QP_W'(quat_x) * QP_W'(quat_z);
			yz_s1 <= QP_W'(quat_y) * QP_W'(quat_z);
			wx_s1 <= QP_W'(quat_w) * QP_W'(quat_x);
			wy_s1 <= QP_W'(quat_w) * QP_W'(quat_y);
			wz_s1 <= QP_W'(quat_w) * QP_W'(quat_z);
		end
	end

	// Form the matrix entries exactly in Q28
	always_comb begin
		m00 = qrv_pkg::ONE_Q28 - ((WW'(yy_s1) + WW'(zz_s1)) <<< 1);
		m01 = (WW'(xy_s1) - WW'(wz_s1)) <<< 1;
		m02 = (WW'(xz_s1) + WW'(wy_s1)) <<< 1;
		m10 = (WW'(xy_s1) + WW'(wz_s1)) <<< 1;
		m11 = qrv_pkg::ONE_Q28 - ((WW'(xx_s1) + WW'(zz_s1)) <<< 1);
		m12 = (WW'(yz_s1) - WW'(wx_s1)) <<< 1;
		m20 = (WW'(xz_s1) - WW'(wy_s1)) <<< 1;
		m21 = (WW'(yz_s1) + WW'(wx_s1)) <<< 1;
		m22 = qrv_pkg::ONE_Q28 - ((WW'(xx_s1) + WW'(yy_s1)) <<< 1);
	end

	// Stage 2: round entries to Q25
	always_ff @(posedge clk) begin
		if (en) begin
			row0_s2 <= '{c0: round_entry(m00), c1: round_entry(m01), c2: round_entry(m02)};
			row1_s2 <= '{c0: round_entry(m10), c1: round_entry(m11), c2: round_entry(m12)};
			row2_s2 <= '{c0: round_entry(m20), c1: round_entry(m21), c2: round_entry(m22)};
		end
	end

endmodule

// File: hw/rtl/qrv_lane.sv
// ----------------------------------------------------------------------------
// qrv_lane: one output coordinate
// Multiplies one matrix row by the vector (stage 3) and sums and rounds
// the three Q41 products to Q16.16 (stage 4), before saturation.
// ----------------------------------------------------------------------------
module qrv_lane (
	input  logic                                clk,
	input  logic                                en,
	input  qrv_pkg::mat_row_t                   row,
	input  qrv_pkg::vec_t                       vec,
	output logic signed [qrv_pkg::ROW_W-1:0]    sum_s4
);

	localparam int PW = qrv_pkg::PROD_W;

	logic signed [qrv_pkg::ENTRY_W-1:0] c0, c1, c2;
	logic signed [qrv_pkg::VEC_W-1:0]   vx, vy, vz;
	logic signed [PW-1:0]               p0_s3, p1_s3, p2_s3;
	logic signed [PW-1:0]               acc;

	assign c0 = row.c0;
	assign c1 = row.c1;
	assign c2 = row.c2;
	assign vx = vec.x;
	assign vy = vec.y;
	assign vz = vec.z;

	// Stage 3: one 32x32 product per column
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s3 <= PW'(c0) * PW'(vx);
			p1_s3 <= PW'(c1) * PW'(vy);
			p2_s3 <= PW'(c2) * PW'(vz);
		end
	end

	// Sum exactly and add half an LSB of Q16.16
	assign acc = p0_s3 + p1_s3 + p2_s3 + qrv_pkg::ROW_RND;

	// Stage 4: drop the fraction bits (floor)
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= acc[qrv_pkg::ROW_SHIFT +: qrv_pkg::ROW_W];
		end
	end

endmodule

// File: hw/rtl/quaternion_rotate_vector.sv
// ----------------------------------------------------------------------------
// quaternion_rotate_vector: rotate a Q16.16 vector by a Q2.14 quaternion
// Expands the quaternion into its rotation matrix and multiplies the vector
// by it, one row per lane; a merging stage saturates and packs the result.
// ----------------------------------------------------------------------------
// The block takes one quaternion and vector per cycle and returns the
// rotated vector: two stages build the matrix, three lanes each multiply
// one row by the vector and round it over two stages, and a final
// register saturates the coordinates to 32 bits. The quaternion is
// used as given, so a non-unit quaternion does not give a rotation. The
// five stages advance together; while a result waits under rot_stall the
// whole pipeline holds and item_stall is raised, otherwise a transfer is
// accepted every cycle.
// ----------------------------------------------------------------------------
module quaternion_rotate_vector (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  qrv_pkg::item_t  item,
	output logic            rot_valid,
	input  logic            rot_stall,
	output qrv_pkg::rot_t   rot
);

	localparam int RW = qrv_pkg::ROW_W;
	localparam int VW = qrv_pkg::VEC_W;
	localparam logic signed [RW-1:0] SAT_MAX = RW'((64'sd1 <<< (VW - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] SAT_MIN = RW'(-(64'sd1 <<< (VW - 1)));

	logic                  en;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	qrv_pkg::vec_t         vec_s1, vec_s2;
	qrv_pkg::mat_row_t     row0_s2, row1_s2, row2_s2;
	logic signed [RW-1:0]  sum0_s4, sum1_s4, sum2_s4;
	qrv_pkg::rot_t         rot_s5;

	// Clamp a rounded row sum to the 32-bit output range
	function automatic logic signed [VW-1:0] sat_out(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] t;
		t = v;
		if (v > SAT_MAX) begin
			t = SAT_MAX;
		end else if (v < SAT_MIN) begin
			t = SAT_MIN;
		end
		return t[VW-1:0];
	endfunction

	// Advance the whole pipeline unless a finished result is held
	assign en         = !(v_s5 && rot_stall);
	assign item_stall = !en;
	assign rot_valid  = v_s5;
	assign rot        = rot_s5;

	// Valid bits travel with the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Delay the vector to meet the finished matrix
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= '{x: item.vec_x, y: item.vec_y, z: item.vec_z};
			vec_s2 <= vec_s1;
		end
	end

	qrv_matrix u_matrix (
		.clk     (clk),
		.en      (en),
		.quat_x  (item.quat_x),
		.quat_y  (item.quat_y),
		.quat_z  (item.quat_z),
		.quat_w  (item.quat_w),
		.row0_s2 (row0_s2),
		.row1_s2 (row1_s2),
		.row2_s2 (row2_s2)
	);

	qrv_lane u_lane_x (
		.clk    (clk),
		.en     (en),
		.row    (row0_s2),
		.vec    (vec_s2),
		.sum_s4 (sum0_s4)
	);

	qrv_lane u_lane_y (
		.clk    (clk),
		.en     (en),
		.row    (row1_s2),
		.vec    (vec_s2),
		.sum_s4 (sum1_s4)
	);

	qrv_lane u_lane_z (
		.clk    (clk),
		.en     (en),
		.row    (row2_s2),
		.vec    (vec_s2),
		.sum_s4 (sum2_s4)
	);

	// Stage 5: merge the lanes, saturate and hold for the output transfer
	always_ff @(posedge clk) begin
		if (en) begin
			rot_s5 <= '{rot_x: sat_out(sum0_s4), rot_y: sat_out(sum1_s4),
				rot_z: sat_out(sum2_s4)};
		end
	end

endmodule

// File: hw/rtl/qrv_checker.sv
// ----------------------------------------------------------------------------
// qrv_checker: port-level checks for the quaternion vector rotator
// Watches both channels of the top level and is attached by bind.
// ----------------------------------------------------------------------------
module qrv_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            item_valid,
	input logic            item_stall,
	input qrv_pkg::item_t  item,
	input logic            rot_valid,
	input logic            rot_stall,
	input qrv_pkg::rot_t   rot
);

	// Input backpressure only comes from a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (rot_valid && rot_stall))
		else $error("item_stall raised without a stalled result");

	// A held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rot_valid && rot_stall) |=> (rot_valid && $stable(rot)))
		else $error("stalled result changed or vanished");

	// A transfer that meets no stall on its way through the pipeline comes out valid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) ##1 !item_stall ##1 !item_stall
		##1 !item_stall ##1 !item_stall |=> rot_valid)
		else $error("result missing after pipeline latency");

	// A zero quaternion passes the vector through unchanged
	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.quat_x == '0 && item.quat_y == '0
		&& item.quat_z == '0 && item.quat_w == '0)
		##1 !item_stall ##1 !item_stall ##1 !item_stall ##1 !item_stall
		|=> (rot.rot_x == $past(item.vec_x, 5) && rot.rot_y == $past(item.vec_y, 5)
		&& rot.rot_z == $past(item.vec_z, 5)))
		else $error("zero quaternion did not pass the vector through");

endmodule

bind quaternion_rotate_vector qrv_checker u_qrv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.item       (item),
	.rot_valid  (rot_valid),
	.rot_stall  (rot_stall),
	.rot        (rot)
);
